/* design/cmh_pkg.sv */
// Shared types, constants and helper functions for the codon Markov histogram.
// No dependencies; every other file but cmh_ram imports this package.
`timescale 1ns / 1ps

package cmh_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int POSITION_BITS = 31;
    localparam int CMD_BITS      = 3;
    localparam int CHAR_BITS     = 8;
    localparam int CODON_BITS    = 6;
    localparam int PAIR_BITS     = 2 * CODON_BITS;
    localparam int OUT_BITS      = 32;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]    COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]    PAIR_SEED = COUNT_BITS'(1);
    localparam logic [1:0]               LAST_PHASE = 2'd2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_BASE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_RD_SINGLE = 3'd2,
        CMD_RD_PAIR   = 3'd3,
        CMD_RD_TOTAL  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READ
    } t_state;

    // Completed codon, as seen by the count update logic
    typedef struct packed {
        logic                  done;
        logic                  valid;
        logic                  pair_ok;
        logic [CODON_BITS-1:0] codon;
        logic [PAIR_BITS-1:0]  pair_addr;
    } t_codon_evt;

    // Bit 2 flags a valid base; low bits T=0 C=1 A=2 G=3
    function automatic logic [2:0] encode_base(input logic [CHAR_BITS-1:0] ch);
        logic [2:0] code;
        case (ch)
            "t", "T": code = 3'b100;
            "c", "C": code = 3'b101;
            "a", "A": code = 3'b110;
            "g", "G": code = 3'b111;
            default:  code = 3'b000;
        endcase
        return code;
    endfunction

    // Saturating increment
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    // Clip a count to the result width
    function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (COUNT_BITS > OUT_BITS) begin
            r = ((v >> OUT_BITS) != '0) ? {OUT_BITS{1'b1}} : OUT_BITS'(v);
        end else begin
            r = OUT_BITS'(v);
        end
        return r;
    endfunction

endpackage

/* design/cmh_if.sv */
// Valid/ready channel interfaces: command input and count result output.
// Depends on cmh_pkg for field widths.
`timescale 1ns / 1ps

interface cmh_in_if import cmh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_BITS-1:0]      cmd;
    logic [CHAR_BITS-1:0]     base_char;
    logic [POSITION_BITS-1:0] window_start;
    logic [POSITION_BITS-1:0] window_end;
    logic [CODON_BITS-1:0]    first_codon;
    logic [CODON_BITS-1:0]    second_codon;

    modport source (output valid, cmd, base_char, window_start, window_end,
                    first_codon, second_codon, input ready);
    modport sink   (input valid, cmd, base_char, window_start, window_end,
                    first_codon, second_codon, output ready);
endinterface

interface cmh_out_if import cmh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] count_value;

    modport source (output valid, count_value, input ready);
    modport sink   (input valid, count_value, output ready);
endinterface

/* design/cmh_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependency.
`timescale 1ns / 1ps

module cmh_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/cmh_framer.sv */
// Reading frame: coding window, base position, held bases and previous codon.
// Depends on cmh_pkg for the codon event type and base encoding.
`timescale 1ns / 1ps

module cmh_framer import cmh_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_base_fire,
    input  logic                     i_start_fire,
    input  logic                     i_reverse,
    input  logic [CHAR_BITS-1:0]     i_base_char,
    input  logic [POSITION_BITS-1:0] i_window_start,
    input  logic [POSITION_BITS-1:0] i_window_end,
    output t_codon_evt               o_evt
);

    logic [1:0]               r_phase,     n_phase;
    logic [2:0]               r_held0,     n_held0;
    logic [2:0]               r_held1,     n_held1;
    logic                     r_prev_vld,  n_prev_vld;
    logic [CODON_BITS-1:0]    r_prev,      n_prev;
    logic [POSITION_BITS-1:0] r_pos,       n_pos;
    logic [POSITION_BITS-1:0] r_win_start, n_win_start;
    logic [POSITION_BITS-1:0] r_win_end,   n_win_end;

    logic       in_window;
    logic [2:0] code;
    logic [2:0] b0, b1, b2;
    t_codon_evt evt;

    assign in_window = (r_pos >= r_win_start) && (r_pos < r_win_end);
    assign code      = encode_base(i_base_char);

    // Assemble the codon, reverse-complementing when asked
    always_comb begin
        if (i_reverse) begin
            b0 = code    ^ 3'b010;
            b1 = r_held1 ^ 3'b010;
            b2 = r_held0 ^ 3'b010;
        end else begin
            b0 = r_held0;
            b1 = r_held1;
            b2 = code;
        end
        evt.done      = i_base_fire && in_window && (r_phase == LAST_PHASE);
        evt.valid     = b0[2] & b1[2] & b2[2];
        evt.codon     = {b0[1:0], b1[1:0], b2[1:0]};
        evt.pair_ok   = evt.valid && r_prev_vld;
        evt.pair_addr = i_reverse ? {evt.codon, r_prev} : {r_prev, evt.codon};
    end

    assign o_evt = evt;

    // Advance frame on each base, reload on start
    always_comb begin
        n_phase     = r_phase;
        n_held0     = r_held0;
        n_held1     = r_held1;
        n_prev_vld  = r_prev_vld;
        n_prev      = r_prev;
        n_pos       = r_pos;
        n_win_start = r_win_start;
        n_win_end   = r_win_end;
        if (i_start_fire) begin
            n_phase     = 2'd0;
            n_held0     = 3'b000;
            n_held1     = 3'b000;
            n_prev_vld  = 1'b0;
            n_pos       = '0;
            n_win_start = i_window_start;
            n_win_end   = i_window_end;
        end else if (i_base_fire) begin
            if (in_window) begin
                if (evt.done) begin
                    n_phase    = 2'd0;
                    n_prev_vld = evt.valid;
                    n_prev     = evt.codon;
                end else begin
                    if (r_phase[0]) begin
                        n_held1 = code;
                    end else begin
                        n_held0 = code;
                    end
                    n_phase = r_phase + 2'd1;
                end
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_held0     <= 3'b000;
            r_held1     <= 3'b000;
            r_prev_vld  <= 1'b0;
            r_prev      <= '0;
            r_pos       <= '0;
            r_win_start <= '0;
            r_win_end   <= POS_MAX;
        end else begin
            r_phase     <= n_phase;
            r_held0     <= n_held0;
            r_held1     <= n_held1;
            r_prev_vld  <= n_prev_vld;
            r_prev      <= n_prev;
            r_pos       <= n_pos;
            r_win_start <= n_win_start;
            r_win_end   <= n_win_end;
        end
    end

endmodule

/* design/codon_markov_histogram.sv */
// Top level of the codon usage counter: sequencer, count memories, result register.
// Depends on cmh_pkg, cmh_if, cmh_ram and cmh_framer.
//
//   port          | dir | transfer
//   --------------+-----+---------------------------------------------------
//   i_in          | in  | one command (base, start, or count read) per transfer
//   o_out         | out | one count per read command
//   i_cfg_we/wdata| in  | reverse_strand register write, no handshake
//
// Base, start and unused commands leave the sequencer idle; a base that completes a
// codon passes through ST_UPDATE and any read through ST_READ, since the registered
// read of the count RAMs is followed by the write-back or result load.
// After reset a clearing pass over all 4096 pair addresses seeds the pair RAM with 1 and the
// single RAM with 0; i_in.ready stays low meanwhile.
// A pending result blocks new commands only while o_out.ready is low.
`timescale 1ns / 1ps

module codon_markov_histogram import cmh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmh_in_if.sink    i_in,
    cmh_out_if.source o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    t_state r_state, n_state;

    logic                  r_reverse;
    logic [PAIR_BITS-1:0]  r_clr_addr;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_wr_single;
    logic                  r_wr_pair;
    logic [CODON_BITS-1:0] r_single_addr;
    logic [PAIR_BITS-1:0]  r_pair_addr;
    t_cmd                  r_rd_sel;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_data;

    logic       in_ready;
    logic       accept;
    logic       base_fire;
    logic       start_fire;
    logic       rd_fire;
    logic       out_free;
    t_codon_evt evt;

    logic                  s_we;
    logic [CODON_BITS-1:0] s_waddr;
    logic [COUNT_BITS-1:0] s_wdata;
    logic [CODON_BITS-1:0] s_raddr;
    logic [COUNT_BITS-1:0] s_rdata;
    logic                  p_we;
    logic [PAIR_BITS-1:0]  p_waddr;
    logic [COUNT_BITS-1:0] p_wdata;
    logic [PAIR_BITS-1:0]  p_raddr;
    logic [COUNT_BITS-1:0] p_rdata;

    // Command decode
    assign accept     = i_in.valid && in_ready;
    assign base_fire  = accept && (i_in.cmd == CMD_BASE);
    assign start_fire = accept && (i_in.cmd == CMD_START);
    assign rd_fire    = accept && ((i_in.cmd == CMD_RD_SINGLE) ||
                                   (i_in.cmd == CMD_RD_PAIR) ||
                                   (i_in.cmd == CMD_RD_TOTAL));
    assign out_free   = !r_out_valid || o_out.ready;

    cmh_framer u_framer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base_fire    (base_fire),
        .i_start_fire   (start_fire),
        .i_reverse      (r_reverse),
        .i_base_char    (i_in.base_char),
        .i_window_start (i_in.window_start),
        .i_window_end   (i_in.window_end),
        .o_evt          (evt)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == {PAIR_BITS{1'b1}}) n_state = ST_IDLE;
            ST_IDLE: begin
                if (evt.done) begin
                    n_state = ST_UPDATE;
                end else if (rd_fire) begin
                    n_state = ST_READ;
                end
            end
            ST_UPDATE: n_state = ST_IDLE;
            ST_READ:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshake and RAM ports
    always_comb begin
        in_ready = 1'b0;
        s_we     = 1'b0;
        s_waddr  = r_single_addr;
        s_wdata  = bump(s_rdata);
        p_we     = 1'b0;
        p_waddr  = r_pair_addr;
        p_wdata  = bump(p_rdata);
        unique case (r_state)
            ST_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr_addr[CODON_BITS-1:0];
                s_wdata = '0;
                p_we    = 1'b1;
                p_waddr = r_clr_addr;
                p_wdata = PAIR_SEED;
            end
            ST_IDLE:   in_ready = out_free;
            ST_UPDATE: begin
                s_we = r_wr_single;
                p_we = r_wr_pair;
            end
            ST_READ:   in_ready = 1'b0;
            default:   in_ready = 1'b0;
        endcase
    end

    // Read addresses come straight from the command or the completed codon
    assign s_raddr = base_fire ? evt.codon : i_in.first_codon;
    assign p_raddr = base_fire ? evt.pair_addr : {i_in.first_codon, i_in.second_codon};

    cmh_ram #(.ADDR_BITS(CODON_BITS), .DATA_BITS(COUNT_BITS)) u_single_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    cmh_ram #(.ADDR_BITS(PAIR_BITS), .DATA_BITS(COUNT_BITS)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_reverse   <= 1'b0;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_wr_single <= 1'b0;
            r_wr_pair   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_reverse <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + PAIR_BITS'(1);
            end
            // Every completed codon bumps the total
            if (evt.done) begin
                r_total     <= bump(r_total);
                r_wr_single <= evt.valid;
                r_wr_pair   <= evt.pair_ok;
            end
            // Load result, drop it once transferred
            if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (evt.done) begin
            r_single_addr <= evt.codon;
            r_pair_addr   <= evt.pair_addr;
        end
        if (rd_fire) begin
            r_rd_sel <= t_cmd'(i_in.cmd);
        end
        if (r_state == ST_READ) begin
            case (r_rd_sel)
                CMD_RD_SINGLE: r_out_data <= clip_out(s_rdata);
                CMD_RD_PAIR:   r_out_data <= clip_out(p_rdata);
                default:       r_out_data <= clip_out(r_total);
            endcase
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.count_value = r_out_data;

endmodule

/* design/cmh_checker.sv */
// Port-level checks on the codon usage counter, bound to the top level.
// Depends on cmh_pkg for command codes and widths.
`timescale 1ns / 1ps

module cmh_checker import cmh_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [CMD_BITS-1:0] i_in_cmd,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [OUT_BITS-1:0] i_out_count_value
);

    logic rd_accept;

    assign rd_accept = i_in_valid && i_in_ready &&
                       ((i_in_cmd == CMD_RD_SINGLE) || (i_in_cmd == CMD_RD_PAIR) ||
                        (i_in_cmd == CMD_RD_TOTAL));

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_count_value))
        else $error("result changed while stalled");

    // Every new result follows an accepted read, with the read state in between
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(rd_accept, 2))
        else $error("result without a read command");

    // A read is in flight once accepted: no command taken behind it
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_accept |=> !i_in_ready)
        else $error("command taken while a read is in flight");

    // Clearing pass keeps the input closed after reset
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open straight after reset");

    // A stalled result blocks new commands
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("command taken while result stalled");

endmodule

bind codon_markov_histogram cmh_checker u_cmh_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_cmd          (i_in.cmd),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_count_value (o_out.count_value)
);

/* bench/codon_markov_histogram_checker.sv */
// Scoreboard for the codon Markov histogram: mirrors the counting and answers each read.
// Depends on cmh_pkg and the cmh_in_if / cmh_out_if channel interfaces.
`timescale 1ns / 1ps

module codon_markov_histogram_checker import cmh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cmh_in_if    i_cmd,
    cmh_out_if   i_res,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_fail_count,
    output int   o_pending
);

    // Mirror of the counter state
    logic                     strand_rev;
    logic [1:0]               frame_phase;
    logic [2:0]               held_code [2];
    logic                     prev_ok;
    logic [CODON_BITS-1:0]    prev_codon;
    logic [POSITION_BITS-1:0] seq_pos;
    logic [POSITION_BITS-1:0] win_lo;
    logic [POSITION_BITS-1:0] win_hi;
    logic [COUNT_BITS-1:0]    single_tab [64];
    logic [COUNT_BITS-1:0]    pair_tab [4096];
    logic [COUNT_BITS-1:0]    codon_count;
    logic [OUT_BITS-1:0]      expected_counts [$];

    // Valid flag in bit 2, nucleotide code in the low bits
    function automatic logic [2:0] char_code(input logic [CHAR_BITS-1:0] ch);
        logic [2:0] code;
        case (ch)
            "t", "T": code = 3'b100;
            "c", "C": code = 3'b101;
            "a", "A": code = 3'b110;
            "g", "G": code = 3'b111;
            default:  code = 3'b000;
        endcase
        return code;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Limit a count to the result width
    function automatic logic [OUT_BITS-1:0] to_result(input logic [COUNT_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (COUNT_BITS > OUT_BITS && (v >> OUT_BITS) != '0) begin
            r = '1;
        end else begin
            r = OUT_BITS'(v);
        end
        return r;
    endfunction

    task automatic clear_frame();
        frame_phase  = '0;
        held_code[0] = '0;
        held_code[1] = '0;
        prev_ok      = 1'b0;
        prev_codon   = '0;
        seq_pos      = '0;
    endtask

    task automatic reset_model();
        strand_rev = 1'b0;
        clear_frame();
        win_lo      = '0;
        win_hi      = POS_MAX;
        codon_count = '0;
        for (int k = 0; k < 64; k++) single_tab[k] = '0;
        for (int k = 0; k < 4096; k++) pair_tab[k] = COUNT_BITS'(1);
        expected_counts.delete();
    endtask

    // Count one completed codon, reverse-complemented on the reverse strand
    task automatic close_codon(input logic [2:0] c0, input logic [2:0] c1,
                               input logic [2:0] c2);
        logic [2:0]            f0;
        logic [2:0]            f1;
        logic [2:0]            f2;
        logic [CODON_BITS-1:0] idx;
        if (strand_rev) begin
            f0 = c2 ^ 3'b010;
            f1 = c1 ^ 3'b010;
            f2 = c0 ^ 3'b010;
        end else begin
            f0 = c0;
            f1 = c1;
            f2 = c2;
        end
        idx = {f0[1:0], f1[1:0], f2[1:0]};
        if (f0[2] && f1[2] && f2[2]) begin
            single_tab[idx] = sat_inc(single_tab[idx]);
            if (prev_ok) begin
                if (strand_rev) begin
                    pair_tab[{idx, prev_codon}] = sat_inc(pair_tab[{idx, prev_codon}]);
                end else begin
                    pair_tab[{prev_codon, idx}] = sat_inc(pair_tab[{prev_codon, idx}]);
                end
            end
            prev_ok    = 1'b1;
            prev_codon = idx;
        end else begin
            prev_ok = 1'b0;
        end
        codon_count = sat_inc(codon_count);
    endtask

    task automatic take_base(input logic [CHAR_BITS-1:0] ch);
        logic [2:0] code;
        code = char_code(ch);
        if (seq_pos >= win_lo && seq_pos < win_hi) begin
            if (frame_phase < LAST_PHASE) begin
                held_code[frame_phase[0]] = code;
                frame_phase = frame_phase + 1'b1;
            end else begin
                close_codon(held_code[0], held_code[1], code);
                frame_phase = '0;
            end
        end
        if (seq_pos != POS_MAX) seq_pos = seq_pos + 1'b1;
    endtask

    // Check the result transfer first, then take the command transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            o_fail_count = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_counts.size() == 0) begin
                    $error("count_value: unexpected transfer, got %0d", i_res.count_value);
                    o_fail_count = o_fail_count + 1;
                end else if (i_res.count_value !== expected_counts[0]) begin
                    $error("count_value: expected %0d, got %0d",
                           expected_counts[0], i_res.count_value);
                    o_fail_count = o_fail_count + 1;
                    void'(expected_counts.pop_front());
                end else begin
                    void'(expected_counts.pop_front());
                end
            end
            if (i_cfg_we) strand_rev = i_cfg_wdata;
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.cmd)
                    CMD_BASE: take_base(i_cmd.base_char);
                    CMD_START: begin
                        clear_frame();
                        win_lo = i_cmd.window_start;
                        win_hi = i_cmd.window_end;
                    end
                    CMD_RD_SINGLE:
                        expected_counts.push_back(to_result(single_tab[i_cmd.first_codon]));
                    CMD_RD_PAIR:
                        expected_counts.push_back(
                            to_result(pair_tab[{i_cmd.first_codon, i_cmd.second_codon}]));
                    CMD_RD_TOTAL: expected_counts.push_back(to_result(codon_count));
                    default: ;
                endcase
            end
        end
        o_pending = expected_counts.size();
    end

endmodule

/* bench/codon_markov_histogram_tb.sv */
// Testbench top for codon_markov_histogram: clock, reset, command stimulus and verdict.
// Depends on cmh_pkg, the channel interfaces, the block and codon_markov_histogram_checker.
`timescale 1ns / 1ps

module codon_markov_histogram_tb;
    import cmh_pkg::*;

    localparam int          RANDOM_ITEMS   = 900;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam logic [2:0]  CMD_SPARE_LO   = 3'd5;
    localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;
    localparam logic [1:0]  CODE_T         = 2'd0;
    localparam logic [1:0]  CODE_C         = 2'd1;
    localparam logic [1:0]  CODE_A         = 2'd2;
    localparam logic [1:0]  CODE_G         = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    int   items_sent  = 0;
    int   quiet_cycles = 0;
    logic calm = 1'b0;

    cmh_in_if  cmd_ch ();
    cmh_out_if cnt_ch ();

    codon_markov_histogram dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (cmd_ch),
        .o_out       (cnt_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    codon_markov_histogram_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (cnt_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // End the run if no transfer happens on either channel for too long
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (cnt_ch.valid && cnt_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer
    initial begin
        int unsigned stall;
        cnt_ch.ready <= 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                cnt_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            cnt_ch.ready <= 1'b1;
            do @(posedge clk); while (!cnt_ch.valid);
            @(negedge clk);
        end
    end

    function automatic logic [CHAR_BITS-1:0] letter(input logic [1:0] code, input logic lower);
        logic [CHAR_BITS-1:0] ch;
        case (code)
            CODE_T:  ch = "T";
            CODE_C:  ch = "C";
            CODE_A:  ch = "A";
            default: ch = "G";
        endcase
        // ASCII lower case differs by one bit
        return lower ? (ch | 8'h20) : ch;
    endfunction

    // Codon built only from a base and its complement
    function automatic logic [CODON_BITS-1:0] focus_codon(input logic [1:0] pick);
        logic [1:0] d [3];
        for (int k = 0; k < 3; k++) d[k] = pick ^ {1'($urandom_range(0, 1)), 1'b0};
        return {d[0], d[1], d[2]};
    endfunction

    // Present one command after a random gap and hold it until the transfer
    task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [CHAR_BITS-1:0] ch,
                             input logic [POSITION_BITS-1:0] ws,
                             input logic [POSITION_BITS-1:0] we,
                             input logic [CODON_BITS-1:0] a, input logic [CODON_BITS-1:0] b);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.cmd          <= cmd;
        cmd_ch.base_char    <= ch;
        cmd_ch.window_start <= ws;
        cmd_ch.window_end   <= we;
        cmd_ch.first_codon  <= a;
        cmd_ch.second_codon <= b;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
        if (cmd <= CMD_RD_TOTAL) items_sent++;
    endtask

    task automatic send_base(input logic [CHAR_BITS-1:0] ch);
        send_item(CMD_BASE, ch, POSITION_BITS'($urandom), POSITION_BITS'($urandom),
                  CODON_BITS'($urandom), CODON_BITS'($urandom));
    endtask

    task automatic send_read(input logic [CMD_BITS-1:0] cmd, input logic [CODON_BITS-1:0] a,
                             input logic [CODON_BITS-1:0] b);
        send_item(cmd, CHAR_BITS'($urandom), POSITION_BITS'($urandom),
                  POSITION_BITS'($urandom), a, b);
    endtask

    // Drop valid and wait until every read has answered and any codon update has drained
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_strand(input logic rev);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= rev;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [POSITION_BITS-1:0] ws;
        logic [POSITION_BITS-1:0] we;
        logic                     focused;
        logic [1:0]               pick;
        logic [CODON_BITS-1:0]    a;
        int unsigned              len;
        int unsigned              r;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.cmd          <= CMD_BASE;
        cmd_ch.base_char    <= '0;
        cmd_ch.window_start <= '0;
        cmd_ch.window_end   <= '0;
        cmd_ch.first_codon  <= '0;
        cmd_ch.second_codon <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: fresh tables, spare command, forward and reverse codons, empty window
        set_strand(1'b0);
        send_read(CMD_RD_TOTAL, '0, '0);
        send_read(CMD_RD_PAIR, '1, '1);
        send_read(CMD_SPARE_HI, '0, '0);
        send_base("A");
        send_base("c");
        send_base("G");
        send_base("t");
        send_base("T");
        send_base("g");
        send_base("N");
        send_base(8'hff);
        send_base(8'h00);
        send_read(CMD_RD_SINGLE, {CODE_A, CODE_C, CODE_G}, '0);
        send_read(CMD_RD_PAIR, {CODE_A, CODE_C, CODE_G}, {CODE_T, CODE_T, CODE_G});
        send_read(CMD_RD_TOTAL, '0, '0);
        set_strand(1'b1);
        send_base("g");
        send_base("c");
        send_base("a");
        send_base("t");
        send_base("t");
        send_base("c");
        send_read(CMD_RD_PAIR, {CODE_G, CODE_A, CODE_A}, {CODE_T, CODE_G, CODE_C});
        send_read(CMD_RD_SINGLE, {CODE_G, CODE_A, CODE_A}, '1);
        set_strand(1'b0);
        send_item(CMD_START, "a", POS_MAX, POS_MAX, '0, '0);
        send_base("a");
        send_base("a");
        send_base("a");
        send_read(CMD_RD_TOTAL, '0, '0);

        // Random phases: a fresh window, then a run of bases with reads mixed in
        while (items_sent < RANDOM_ITEMS + 30) begin
            if ($urandom_range(0, 2) == 0) set_strand(1'($urandom_range(0, 1)));
            calm    = ($urandom_range(0, 3) == 0);
            focused = 1'($urandom_range(0, 1));
            pick    = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: begin
                    ws = '0;
                    we = POS_MAX;
                end
                1: begin
                    ws = POSITION_BITS'($urandom_range(0, 6));
                    we = ws + POSITION_BITS'($urandom_range(0, 90));
                end
                2: begin
                    ws = POSITION_BITS'($urandom_range(0, 20));
                    we = POSITION_BITS'($urandom_range(0, ws));
                end
                3: begin
                    ws = POSITION_BITS'($urandom);
                    we = POSITION_BITS'($urandom);
                end
                default: begin
                    ws = POSITION_BITS'($urandom_range(0, 3));
                    we = ws + POSITION_BITS'($urandom_range(20, 120));
                end
            endcase
            send_item(CMD_START, CHAR_BITS'($urandom), ws, we,
                      CODON_BITS'($urandom), CODON_BITS'($urandom));
            len = $urandom_range(20, 90);
            repeat (len) begin
                r = $urandom_range(0, 99);
                a = focused ? focus_codon(pick) : CODON_BITS'($urandom);
                if (r < 70) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_base(CHAR_BITS'($urandom));
                    end else if (focused) begin
                        send_base(letter(pick ^ {1'($urandom_range(0, 1)), 1'b0},
                                         1'($urandom_range(0, 1))));
                    end else begin
                        send_base(letter(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
                    end
                end else if (r < 78) begin
                    send_read(CMD_RD_SINGLE, a, CODON_BITS'($urandom));
                end else if (r < 92) begin
                    send_read(CMD_RD_PAIR, a,
                              focused ? focus_codon(pick) : CODON_BITS'($urandom));
                end else if (r < 97) begin
                    send_read(CMD_RD_TOTAL, a, CODON_BITS'($urandom));
                end else begin
                    send_read(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), a,
                              CODON_BITS'($urandom));
                end
            end
        end

        // Drain, then give any stray result time to show up
        calm = 1'b0;
        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
